@@ design/spot_pkg.sv @@
package spot_pkg;

    // item stages from input accept to the output register
    localparam int NUM_STAGES = 6;

    // result beat width: overlap flag padded to a whole byte
    localparam int OUT_TDATA_W = 8;

    // shape kind codes as carried on tuser
    typedef enum logic {
        KIND_BOX    = 1'b0,
        KIND_CIRCLE = 1'b1
    } shape_kind_t;

    // pair code is {self_kind, other_kind}
    typedef enum logic [1:0] {
        PAIR_BOX_BOX       = 2'b00,
        PAIR_BOX_CIRCLE    = 2'b01,
        PAIR_CIRCLE_BOX    = 2'b10,
        PAIR_CIRCLE_CIRCLE = 2'b11
    } pair_mode_t;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    typedef struct packed {
        stage_vec_t en;
        stage_vec_t vld;
    } pipe_ctl_t;

endpackage

@@ design/spot_pipe_ctl.sv @@
module spot_pipe_ctl
    import spot_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output pipe_ctl_t ctl
);

    stage_vec_t vld_reg;
    stage_vec_t vld_next;
    stage_vec_t en_c;

    // a stage loads when it is empty or its successor moves on; bubbles collapse
    always_comb begin
        en_c[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en_c[k] = !vld_reg[k] || en_c[k+1];
        end
        vld_next[0] = en_c[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = en_c[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en_c[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign ctl.en   = en_c;
    assign ctl.vld  = vld_reg;

endmodule

@@ design/spot_geom.sv @@
module spot_geom
    import spot_pkg::*;
#(
    parameter int W = 24
) (
    input  logic                aclk,
    input  logic [2:0]          en,
    input  logic                self_kind,
    input  logic signed [W-1:0] self_x,
    input  logic signed [W-1:0] self_y,
    input  logic [W-2:0]        self_w,
    input  logic [W-2:0]        self_h,
    input  logic signed [W-1:0] move_x,
    input  logic signed [W-1:0] move_y,
    input  logic                other_kind,
    input  logic signed [W-1:0] other_x,
    input  logic signed [W-1:0] other_y,
    input  logic [W-2:0]        other_w,
    input  logic [W-2:0]        other_h,
    output logic signed [W+1:0] cx,
    output logic signed [W+1:0] cy,
    output logic signed [W+1:0] px,
    output logic signed [W+1:0] py,
    output logic [W-1:0]        radius,
    output logic                bb_hit,
    output logic                is_bb
);

    localparam int EW = W + 2;

    // stage 1: move the self shape
    logic signed [W:0] sx1_reg, sy1_reg;
    logic [W-2:0]      sw1_reg, sh1_reg, ow1_reg, oh1_reg;
    logic signed [W-1:0] ox1_reg, oy1_reg;
    pair_mode_t        mode1_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sx1_reg   <= (W+1)'(self_x) + (W+1)'(move_x);
            sy1_reg   <= (W+1)'(self_y) + (W+1)'(move_y);
            sw1_reg   <= self_w;
            sh1_reg   <= self_h;
            ox1_reg   <= other_x;
            oy1_reg   <= other_y;
            ow1_reg   <= other_w;
            oh1_reg   <= other_h;
            mode1_reg <= pair_mode_t'({self_kind, other_kind});
        end
    end

    // stage 2: box far edges and role selection. Point "a" is the circle
    // center (or the first box); box "b" is the box to clamp into. For two
    // circles b degenerates to the other center, so the clamp returns it.
    logic signed [EW-1:0] sx_e, sy_e, sx_f, sy_f, ox_e, oy_e, ox_f, oy_f;
    logic signed [EW-1:0] ax0_next, ay0_next, ax1_next, ay1_next;
    logic signed [EW-1:0] bx0_next, by0_next, bx1_next, by1_next;
    logic [W-1:0]         r_next;
    logic                 bb_next;

    logic signed [EW-1:0] ax0_reg, ay0_reg, ax1_reg, ay1_reg;
    logic signed [EW-1:0] bx0_reg, by0_reg, bx1_reg, by1_reg;
    logic [W-1:0]         r2_reg;
    logic                 bb2_reg;

    always_comb begin
        sx_e = EW'(sx1_reg);
        sy_e = EW'(sy1_reg);
        sx_f = sx_e + $signed({3'b000, sw1_reg});
        sy_f = sy_e + $signed({3'b000, sh1_reg});
        ox_e = EW'(ox1_reg);
        oy_e = EW'(oy1_reg);
        ox_f = ox_e + $signed({3'b000, ow1_reg});
        oy_f = oy_e + $signed({3'b000, oh1_reg});
        unique case (mode1_reg)
            PAIR_BOX_BOX: begin
                ax0_next = sx_e;  ay0_next = sy_e;
                ax1_next = sx_f;  ay1_next = sy_f;
                bx0_next = ox_e;  by0_next = oy_e;
                bx1_next = ox_f;  by1_next = oy_f;
                r_next   = '0;
                bb_next  = 1'b1;
            end
            PAIR_CIRCLE_CIRCLE: begin
                ax0_next = sx_e;  ay0_next = sy_e;
                ax1_next = sx_e;  ay1_next = sy_e;
                bx0_next = ox_e;  by0_next = oy_e;
                bx1_next = ox_e;  by1_next = oy_e;
                r_next   = {1'b0, sw1_reg} + {1'b0, ow1_reg};
                bb_next  = 1'b0;
            end
            PAIR_CIRCLE_BOX: begin
                ax0_next = sx_e;  ay0_next = sy_e;
                ax1_next = sx_e;  ay1_next = sy_e;
                bx0_next = ox_e;  by0_next = oy_e;
                bx1_next = ox_f;  by1_next = oy_f;
                r_next   = {1'b0, sw1_reg};
                bb_next  = 1'b0;
            end
            PAIR_BOX_CIRCLE: begin
                ax0_next = ox_e;  ay0_next = oy_e;
                ax1_next = ox_e;  ay1_next = oy_e;
                bx0_next = sx_e;  by0_next = sy_e;
                bx1_next = sx_f;  by1_next = sy_f;
                r_next   = {1'b0, ow1_reg};
                bb_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ax0_reg <= ax0_next;
            ay0_reg <= ay0_next;
            ax1_reg <= ax1_next;
            ay1_reg <= ay1_next;
            bx0_reg <= bx0_next;
            by0_reg <= by0_next;
            bx1_reg <= bx1_next;
            by1_reg <= by1_next;
            r2_reg  <= r_next;
            bb2_reg <= bb_next;
        end
    end

    // stage 3: strict box overlap and clamp of the center into box b
    logic signed [EW-1:0] px_next, py_next;
    logic                 hit_next;

    always_comb begin
        hit_next = (ax0_reg < bx1_reg) && (ax1_reg > bx0_reg) &&
                   (ay0_reg < by1_reg) && (ay1_reg > by0_reg);
        if (ax0_reg < bx0_reg) begin
            px_next = bx0_reg;
        end else if (ax0_reg > bx1_reg) begin
            px_next = bx1_reg;
        end else begin
            px_next = ax0_reg;
        end
        if (ay0_reg < by0_reg) begin
            py_next = by0_reg;
        end else if (ay0_reg > by1_reg) begin
            py_next = by1_reg;
        end else begin
            py_next = ay0_reg;
        end
    end

    logic signed [EW-1:0] cx3_reg, cy3_reg, px3_reg, py3_reg;
    logic [W-1:0]         r3_reg;
    logic                 hit3_reg, bb3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            cx3_reg  <= ax0_reg;
            cy3_reg  <= ay0_reg;
            px3_reg  <= px_next;
            py3_reg  <= py_next;
            r3_reg   <= r2_reg;
            hit3_reg <= hit_next;
            bb3_reg  <= bb2_reg;
        end
    end

    assign cx     = cx3_reg;
    assign cy     = cy3_reg;
    assign px     = px3_reg;
    assign py     = py3_reg;
    assign radius = r3_reg;
    assign bb_hit = hit3_reg;
    assign is_bb  = bb3_reg;

endmodule

@@ design/spot_dist.sv @@
module spot_dist
    import spot_pkg::*;
#(
    parameter int W = 24
) (
    input  logic                aclk,
    input  logic [2:0]          en,
    input  logic signed [W+1:0] cx,
    input  logic signed [W+1:0] cy,
    input  logic signed [W+1:0] px,
    input  logic signed [W+1:0] py,
    input  logic [W-1:0]        radius,
    input  logic                bb_hit,
    input  logic                is_bb,
    output logic                overlap
);

    localparam int EW = W + 2;
    localparam int MW = W + 2;
    localparam int SW = 2 * MW + 1;

    // stage 4: absolute axis distances, both subtraction orders in parallel
    logic signed [EW:0] dxa, dxb, dya, dyb;
    logic [MW-1:0]      mx_next, my_next;

    always_comb begin
        dxa = (EW+1)'(cx) - (EW+1)'(px);
        dxb = (EW+1)'(px) - (EW+1)'(cx);
        dya = (EW+1)'(cy) - (EW+1)'(py);
        dyb = (EW+1)'(py) - (EW+1)'(cy);
        mx_next = dxa[EW] ? dxb[MW-1:0] : dxa[MW-1:0];
        my_next = dya[EW] ? dyb[MW-1:0] : dya[MW-1:0];
    end

    logic [MW-1:0] mx4_reg, my4_reg;
    logic [W-1:0]  r4_reg;
    logic          hit4_reg, bb4_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mx4_reg  <= mx_next;
            my4_reg  <= my_next;
            r4_reg   <= radius;
            hit4_reg <= bb_hit;
            bb4_reg  <= is_bb;
        end
    end

    // stage 5: squares
    logic [2*MW-1:0] sqx5_reg, sqy5_reg;
    logic [2*W-1:0]  rr5_reg;
    logic            hit5_reg, bb5_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sqx5_reg <= mx4_reg * mx4_reg;
            sqy5_reg <= my4_reg * my4_reg;
            rr5_reg  <= r4_reg * r4_reg;
            hit5_reg <= hit4_reg;
            bb5_reg  <= bb4_reg;
        end
    end

    // stage 6: distance sum against radius squared; touching counts
    logic [SW-1:0] dist_sum;
    logic          ovl_next;

    always_comb begin
        dist_sum = {1'b0, sqx5_reg} + {1'b0, sqy5_reg};
        ovl_next = bb5_reg ? hit5_reg : (dist_sum <= SW'(rr5_reg));
    end

    logic ovl6_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            ovl6_reg <= ovl_next;
        end
    end

    assign overlap = ovl6_reg;

endmodule

@@ design/shape_pair_overlap_test.sv @@
// Shape pair overlap test.
// Input stream: one beat carries one pair, a self shape moved by (move_x, move_y)
// and a still other shape; each is a box (corner, width, height) or a circle
// (center, radius in the width field). s_tuser carries the two kinds, s_tdata
// the coordinates in signed Q15.8.
// Result stream: one beat per input beat, in order, m_tdata bit 0 = overlap.
// Box/box is a strict overlap; circle tests count touching as a hit.
// Throughput: one pair per cycle while the receiver takes results, through the
// six-stage pipeline (move, role select, clamp, distance, square, compare),
// with the squarers in a stage of their own.
// Backpressure: each stage holds its beat while the next stage is full and stalled, so a
// stalled receiver fills the empty slots first; s_tready stays high as long as
// some stage is empty, and drops only when all six hold a beat and m_tready is low.
// Reset: aresetn low clears every stage valid; pending beats are dropped and
// m_tvalid is low in the cycle after reset.
module shape_pair_overlap_test
    import spot_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // self_x, self_y, self_w, self_h, move_x, move_y, other_x, other_y,
    // other_w, other_h; zero padded to whole bytes
    input  logic [((10*COORD_WIDTH-4+7)/8)*8-1:0] s_tdata,
    // self_kind, other_kind
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // overlap; zero padded
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int W      = COORD_WIDTH;
    localparam int OFF_SX = 0;
    localparam int OFF_SY = W;
    localparam int OFF_SW = 2 * W;
    localparam int OFF_SH = 3 * W - 1;
    localparam int OFF_MX = 4 * W - 2;
    localparam int OFF_MY = 5 * W - 2;
    localparam int OFF_OX = 6 * W - 2;
    localparam int OFF_OY = 7 * W - 2;
    localparam int OFF_OW = 8 * W - 2;
    localparam int OFF_OH = 9 * W - 3;

    pipe_ctl_t ctl;

    spot_pipe_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    logic signed [W+1:0] cx, cy, px, py;
    logic [W-1:0]        radius;
    logic                bb_hit, is_bb, overlap;

    spot_geom #(.W(W)) u_geom (
        .aclk       (aclk),
        .en         (ctl.en[2:0]),
        .self_kind  (s_tuser[0]),
        .self_x     ($signed(s_tdata[OFF_SX +: W])),
        .self_y     ($signed(s_tdata[OFF_SY +: W])),
        .self_w     (s_tdata[OFF_SW +: W-1]),
        .self_h     (s_tdata[OFF_SH +: W-1]),
        .move_x     ($signed(s_tdata[OFF_MX +: W])),
        .move_y     ($signed(s_tdata[OFF_MY +: W])),
        .other_kind (s_tuser[1]),
        .other_x    ($signed(s_tdata[OFF_OX +: W])),
        .other_y    ($signed(s_tdata[OFF_OY +: W])),
        .other_w    (s_tdata[OFF_OW +: W-1]),
        .other_h    (s_tdata[OFF_OH +: W-1]),
        .cx         (cx),
        .cy         (cy),
        .px         (px),
        .py         (py),
        .radius     (radius),
        .bb_hit     (bb_hit),
        .is_bb      (is_bb)
    );

    spot_dist #(.W(W)) u_dist (
        .aclk    (aclk),
        .en      (ctl.en[5:3]),
        .cx      (cx),
        .cy      (cy),
        .px      (px),
        .py      (py),
        .radius  (radius),
        .bb_hit  (bb_hit),
        .is_bb   (is_bb),
        .overlap (overlap)
    );

    assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, overlap};

    // input is held off only when every stage is occupied and the output stalls
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready == !(&ctl.vld && !m_tready)))
        else $error("s_tready does not follow pipeline occupancy");

    // an accepted beat lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ctl.vld[0])
        else $error("accepted beat lost at pipeline entry");

    // a stalled stage keeps its beat
    a_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.vld[2] && !ctl.en[2]) |=> ctl.vld[2])
        else $error("stalled stage dropped its beat");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (ctl.vld == '0))
        else $error("pipeline not empty after reset");

endmodule

@@ dv/shape_pair_overlap_checker.sv @@
package spot_tb_pkg;

    import spot_pkg::*;

    localparam int COORD_W    = 24;
    localparam int PAIR_BITS  = 10*COORD_W - 4;
    localparam int IN_TDATA_W = ((PAIR_BITS + 7) / 8) * 8;

    // laid out so that the struct is s_tdata without its pad bits
    typedef struct packed {
        logic [COORD_W-2:0]        other_h;
        logic [COORD_W-2:0]        other_w;
        logic signed [COORD_W-1:0] other_y;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] move_y;
        logic signed [COORD_W-1:0] move_x;
        logic [COORD_W-2:0]        self_h;
        logic [COORD_W-2:0]        self_w;
        logic signed [COORD_W-1:0] self_y;
        logic signed [COORD_W-1:0] self_x;
    } shape_pair_t;

endpackage

module shape_pair_overlap_checker
    import spot_pkg::*;
    import spot_tb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending,
    output int                     checked,
    output int                     hits
);

    logic overlap_due[$];

    function automatic longint sq(longint v);
        return v * v;
    endfunction

    function automatic logic circle_box_hit(longint cx, longint cy, longint r,
                                            longint bx, longint by,
                                            longint bw, longint bh);
        longint px, py;
        px = (cx < bx) ? bx : (cx > bx + bw) ? bx + bw : cx;
        py = (cy < by) ? by : (cy > by + bh) ? by + bh : cy;
        return sq(cx - px) + sq(cy - py) <= sq(r);
    endfunction

    function automatic logic predict_overlap(shape_kind_t sk, shape_kind_t ok,
                                             shape_pair_t p);
        longint sx, sy, sw, sh, ox, oy, ow, oh;
        sx = longint'($signed(p.self_x)) + longint'($signed(p.move_x));
        sy = longint'($signed(p.self_y)) + longint'($signed(p.move_y));
        sw = longint'(p.self_w);
        sh = longint'(p.self_h);
        ox = longint'($signed(p.other_x));
        oy = longint'($signed(p.other_y));
        ow = longint'(p.other_w);
        oh = longint'(p.other_h);
        case (pair_mode_t'({sk, ok}))
            PAIR_BOX_BOX: begin
                // strict on both axes: touching edges miss
                return sx < ox + ow && sx + sw > ox && sy < oy + oh && sy + sh > oy;
            end
            PAIR_CIRCLE_CIRCLE: begin
                return sq(sx - ox) + sq(sy - oy) <= sq(sw + ow);
            end
            PAIR_CIRCLE_BOX: begin
                return circle_box_hit(sx, sy, sw, ox, oy, ow, oh);
            end
            default: begin
                return circle_box_hit(ox, oy, ow, sx, sy, sw, sh);
            end
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        logic due;
        if (!aresetn) begin
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
            hits       <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (overlap_due.size() == 0) begin
                    $error("result beat with nothing expected: overlap=%0d", m_tdata[0]);
                    fail_count <= fail_count + 1;
                end else begin
                    due = overlap_due.pop_front();
                    checked <= checked + 1;
                    if (due)
                        hits <= hits + 1;
                    if (m_tdata[0] !== due) begin
                        $error("overlap mismatch: expected %0d, actual %0d", due, m_tdata[0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                overlap_due = {overlap_due,
                               predict_overlap(shape_kind_t'(s_tuser[0]),
                                               shape_kind_t'(s_tuser[1]),
                                               shape_pair_t'(s_tdata[PAIR_BITS-1:0]))};
            pending <= overlap_due.size();
        end
    end

endmodule

@@ dv/shape_pair_overlap_test_tb.sv @@
module shape_pair_overlap_test_tb;

    import spot_pkg::*;
    import spot_tb_pkg::*;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count, pending, checked, hits;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int mode_sent[4] = '{0, 0, 0, 0};

    initial forever #6 aclk = ~aclk;

    shape_pair_overlap_test #(.COORD_WIDTH(COORD_W)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    shape_pair_overlap_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .hits       (hits)
    );

    always @(posedge aclk) begin
        m_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end

    task automatic send_pair(input shape_kind_t sk, input int sx, input int sy,
                             input int sw, input int sh, input int mx, input int my,
                             input shape_kind_t ok, input int ox, input int oy,
                             input int ow, input int oh);
        shape_pair_t p;
        p.self_x  = COORD_W'(sx);
        p.self_y  = COORD_W'(sy);
        p.self_w  = (COORD_W-1)'(sw);
        p.self_h  = (COORD_W-1)'(sh);
        p.move_x  = COORD_W'(mx);
        p.move_y  = COORD_W'(my);
        p.other_x = COORD_W'(ox);
        p.other_y = COORD_W'(oy);
        p.other_w = (COORD_W-1)'(ow);
        p.other_h = (COORD_W-1)'(oh);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-PAIR_BITS){1'b0}}, p};
        s_tuser  <= {ok, sk};
        mode_sent[{sk, ok}]++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender off until every predicted beat has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    function automatic int rand_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom());
        return int'(v);
    endfunction

    function automatic shape_kind_t rand_kind();
        return shape_kind_t'($urandom_range(0, 1));
    endfunction

    task automatic send_random_pair;
        int span, ox, oy, mx, my, off_x, off_y;
        if ($urandom_range(0, 99) < 20) begin
            send_pair(rand_kind(), rand_coord(), rand_coord(),
                      $urandom_range(0, 8388607), $urandom_range(0, 8388607),
                      rand_coord(), rand_coord(), rand_kind(), rand_coord(), rand_coord(),
                      $urandom_range(0, 8388607), $urandom_range(0, 8388607));
        end else begin
            // shapes of one scale placed near each other, so hits and misses mix
            span  = 1 << $urandom_range(2, 21);
            ox    = rand_coord();
            oy    = rand_coord();
            mx    = $urandom_range(0, 2 * span);
            my    = $urandom_range(0, 2 * span);
            mx    = mx - span;
            my    = my - span;
            off_x = $urandom_range(0, 3 * span);
            off_y = $urandom_range(0, 3 * span);
            send_pair(rand_kind(), ox + off_x - 2 * span - mx, oy + off_y - 2 * span - my,
                      $urandom_range(0, span), $urandom_range(0, span), mx, my,
                      rand_kind(), ox, oy, $urandom_range(0, span), $urandom_range(0, span));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner cases, Q15.8 so 256 is one unit
        send_pair(KIND_BOX, 0, 0, 2560, 2560, 0, 0, KIND_BOX, 1280, 1280, 2560, 2560);
        send_pair(KIND_BOX, 0, 0, 2560, 2560, 0, 0, KIND_BOX, 2560, 0, 256, 256);
        send_pair(KIND_BOX, 0, 2560, 2560, 256, 0, 0, KIND_BOX, 0, 0, 2560, 2560);
        send_pair(KIND_BOX, 0, 0, 0, 2560, 1280, 0, KIND_BOX, 0, 0, 2560, 2560);
        send_pair(KIND_BOX, -5120, 0, 256, 256, 5120, 0, KIND_BOX, 0, 0, 512, 512);
        send_pair(KIND_CIRCLE, 0, 0, 1024, 77, 0, 0, KIND_CIRCLE, 2560, 0, 1536, 999);
        send_pair(KIND_CIRCLE, 0, 0, 1024, 0, -1, 0, KIND_CIRCLE, 2560, 0, 1536, 0);
        send_pair(KIND_CIRCLE, -768, -1024, 1280, 9999, 0, 0, KIND_BOX, 0, 0, 2560, 2560);
        send_pair(KIND_CIRCLE, -768, -1024, 1279, 0, 0, 0, KIND_BOX, 0, 0, 2560, 2560);
        send_pair(KIND_CIRCLE, 1280, 1280, 1, 0, 0, 0, KIND_BOX, 0, 0, 2560, 2560);
        send_pair(KIND_BOX, 0, 0, 512, 512, 0, 0, KIND_CIRCLE, 768, 256, 256, 4242);
        send_pair(KIND_BOX, 0, 0, 512, 512, 0, 0, KIND_CIRCLE, 768, 256, 255, 0);
        send_pair(KIND_CIRCLE, 2560, 1000, 0, 0, 0, 0, KIND_BOX, 0, 0, 2560, 2560);
        send_pair(KIND_CIRCLE, 5, 5, 0, 0, 0, 0, KIND_CIRCLE, 5, 5, 0, 0);
        send_pair(KIND_CIRCLE, 5, 5, 0, 0, 1, 0, KIND_CIRCLE, 5, 5, 0, 0);
        send_pair(KIND_BOX, 0, 0, 0, 0, 0, 0, KIND_BOX, 0, 0, 0, 0);
        send_pair(KIND_BOX, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                  KIND_BOX, -8388608, -8388608, 8388607, 8388607);
        send_pair(KIND_BOX, -8388608, -8388608, 8388607, 8388607, -8388608, -8388608,
                  KIND_BOX, -8388608, -8388608, 8388607, 8388607);
        send_pair(KIND_BOX, -8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
                  KIND_BOX, 0, 0, 8388607, 8388607);
        send_pair(KIND_CIRCLE, -8388608, -8388608, 8388607, 8388607, -8388608, -8388608,
                  KIND_CIRCLE, 8388607, 8388607, 8388607, 8388607);
        send_pair(KIND_CIRCLE, 8388607, 8388607, 8388607, 0, 8388607, 8388607,
                  KIND_CIRCLE, 8388607, 8388607, 8388607, 0);
        send_pair(KIND_CIRCLE, 0, 0, 8388607, 0, 0, 0,
                  KIND_BOX, -8388608, -8388608, 8388607, 8388607);
        send_pair(KIND_BOX, -8388608, 8388607, 8388607, 8388607, -8388608, 8388607,
                  KIND_CIRCLE, -8388608, 8388607, 8388607, 8388607);
        drain();

        // phases: free flow, sender gaps, receiver stalls, light both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 49; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 49; end
                default: begin tx_idle_pct = 11; rx_stall_pct <= 11; end
            endcase
            for (int i = 0; i < 100; i++)
                send_random_pair();
            drain();
        end

        repeat (NUM_STAGES + 4) @(posedge aclk);
        $display("sent box/box %0d, box/circle %0d, circle/box %0d, circle/circle %0d pairs",
                 mode_sent[PAIR_BOX_BOX], mode_sent[PAIR_BOX_CIRCLE],
                 mode_sent[PAIR_CIRCLE_BOX], mode_sent[PAIR_CIRCLE_CIRCLE]);
        $display("%0d results checked (%0d overlaps) across idle and stall phases",
                 checked, hits);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout: %0d results still due", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
design/spot_pkg.sv
design/spot_pipe_ctl.sv
design/spot_geom.sv
design/spot_dist.sv
design/shape_pair_overlap_test.sv
dv/shape_pair_overlap_checker.sv
dv/shape_pair_overlap_test_tb.sv
